// ----- rtl/core/spq_pkg.sv -----
// shared types, constants and codes of the sorted priority queue
package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ID_W        = 16;
    localparam int PRI_W       = 8;
    localparam int KIND_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 5;
    localparam int ENTRY_W     = ID_W + PRI_W;

    // operation codes
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POP    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [PRI_W-1:0] pri;
    } t_entry;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [ID_W-1:0]        rid;
        logic [PRI_W-1:0]       rpri;
        logic [COUNT_OUT_W-1:0] count;
        logic                   empty;
    } t_result;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        t_entry            wdata;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_WALK,
        ST_INS_PLACE,
        ST_POP_READ,
        ST_DEL_FIND,
        ST_DEL_SHIFT,
        ST_DONE
    } t_state;

endpackage

// ----- rtl/core/spq_ram.sv -----
// generic single write port ram with registered read
module spq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/spq_ctrl.sv -----
// sequencer that walks the entry ram for insert, pop and delete
module spq_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [spq_pkg::KIND_W-1:0]        i_kind,
    input  logic [spq_pkg::ID_W-1:0]          i_id,
    input  logic [spq_pkg::PRI_W-1:0]         i_pri,
    output spq_pkg::t_mem_req                 o_mem,
    input  spq_pkg::t_entry                   i_rdata,
    output logic                              o_res_valid,
    input  logic                              i_res_ready,
    output spq_pkg::t_result                  o_res
);

    localparam int CW = spq_pkg::CNT_W;
    localparam int AW = spq_pkg::ADDR_W;

    spq_pkg::t_state r_state, n_state;
    logic [CW-1:0]                  r_count, n_count;
    logic [AW-1:0]                  r_idx, n_idx;
    logic [spq_pkg::ID_W-1:0]       r_id, n_id;
    logic [spq_pkg::PRI_W-1:0]      r_pri, n_pri;
    logic [spq_pkg::STATUS_W-1:0]   r_status, n_status;
    logic [spq_pkg::ID_W-1:0]       r_rid, n_rid;
    logic [spq_pkg::PRI_W-1:0]      r_rpri, n_rpri;

    logic [CW:0]   idx_p1, idx_p2, cnt_ext;
    logic [CW-1:0] cnt_m1;
    logic [AW-1:0] idx_m1, idx_m2;
    logic          full, empty, last_find, last_shift, shift_up, id_hit;

    assign idx_p1     = {{(CW+1-AW){1'b0}}, r_idx} + 1'b1;
    assign idx_p2     = {{(CW+1-AW){1'b0}}, r_idx} + 2'd2;
    assign cnt_ext    = {1'b0, r_count};
    assign cnt_m1     = r_count - 1'b1;
    assign idx_m1     = r_idx - 1'b1;
    assign idx_m2     = r_idx - 2'd2;
    assign full       = (cnt_ext >= (CW+1)'(spq_pkg::QUEUE_DEPTH));
    assign empty      = (r_count == '0);
    assign last_find  = (idx_p1 >= cnt_ext);
    assign last_shift = (idx_p2 >= cnt_ext);
    assign shift_up   = (i_rdata.pri > r_pri);
    assign id_hit     = (i_rdata.id == r_id);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            spq_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_kind)
                        spq_pkg::KIND_INSERT: begin
                            if (full) n_state = spq_pkg::ST_DONE;
                            else if (empty) n_state = spq_pkg::ST_INS_PLACE;
                            else n_state = spq_pkg::ST_INS_WALK;
                        end
                        spq_pkg::KIND_POP: begin
                            n_state = empty ? spq_pkg::ST_DONE : spq_pkg::ST_POP_READ;
                        end
                        spq_pkg::KIND_DELETE: begin
                            n_state = empty ? spq_pkg::ST_DONE : spq_pkg::ST_DEL_FIND;
                        end
                        default: n_state = spq_pkg::ST_DONE;
                    endcase
                end
            end
            spq_pkg::ST_INS_WALK: begin
                if (!shift_up) n_state = spq_pkg::ST_DONE;
                else if (r_idx == AW'(1)) n_state = spq_pkg::ST_INS_PLACE;
            end
            spq_pkg::ST_INS_PLACE: n_state = spq_pkg::ST_DONE;
            spq_pkg::ST_POP_READ:  n_state = spq_pkg::ST_DONE;
            spq_pkg::ST_DEL_FIND: begin
                if (last_find) n_state = spq_pkg::ST_DONE;
                else if (id_hit) n_state = spq_pkg::ST_DEL_SHIFT;
            end
            spq_pkg::ST_DEL_SHIFT: begin
                if (last_shift) n_state = spq_pkg::ST_DONE;
            end
            spq_pkg::ST_DONE: begin
                if (i_res_ready) n_state = spq_pkg::ST_IDLE;
            end
            default: n_state = spq_pkg::ST_IDLE;
        endcase
    end

    // datapath and ram requests
    always_comb begin
        n_count     = r_count;
        n_idx       = r_idx;
        n_id        = r_id;
        n_pri       = r_pri;
        n_status    = r_status;
        n_rid       = r_rid;
        n_rpri      = r_rpri;
        o_mem.we    = 1'b0;
        o_mem.waddr = r_idx;
        o_mem.wdata = '{id: r_id, pri: r_pri};
        o_mem.raddr = '0;
        unique case (r_state)
            spq_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_id     = i_id;
                    n_pri    = i_pri;
                    n_status = spq_pkg::STATUS_OK;
                    n_rid    = '0;
                    n_rpri   = '0;
                    case (i_kind)
                        spq_pkg::KIND_INSERT: begin
                            if (full) begin
                                n_status = spq_pkg::STATUS_FULL;
                            end else begin
                                n_idx       = r_count[AW-1:0];
                                o_mem.raddr = cnt_m1[AW-1:0];
                            end
                        end
                        spq_pkg::KIND_POP: begin
                            if (empty) begin
                                n_status = spq_pkg::STATUS_EMPTY;
                            end else begin
                                o_mem.raddr = cnt_m1[AW-1:0];
                                n_count     = cnt_m1;
                            end
                        end
                        spq_pkg::KIND_DELETE: begin
                            n_idx = '0;
                            if (empty) n_status = spq_pkg::STATUS_NOT_FOUND;
                        end
                        default: ;
                    endcase
                end
            end
            spq_pkg::ST_INS_WALK: begin
                o_mem.we = 1'b1;
                if (shift_up) begin
                    o_mem.wdata = i_rdata;
                    o_mem.raddr = idx_m2;
                    n_idx       = idx_m1;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            spq_pkg::ST_INS_PLACE: begin
                o_mem.we = 1'b1;
                n_count  = r_count + 1'b1;
            end
            spq_pkg::ST_POP_READ: begin
                n_rid  = i_rdata.id;
                n_rpri = i_rdata.pri;
            end
            spq_pkg::ST_DEL_FIND: begin
                o_mem.raddr = idx_p1[AW-1:0];
                if (id_hit) begin
                    n_rid  = i_rdata.id;
                    n_rpri = i_rdata.pri;
                    if (last_find) n_count = cnt_m1;
                end else if (last_find) begin
                    n_status = spq_pkg::STATUS_NOT_FOUND;
                end else begin
                    n_idx = idx_p1[AW-1:0];
                end
            end
            spq_pkg::ST_DEL_SHIFT: begin
                // entry idx+1 arrives, moves down one place
                o_mem.we    = 1'b1;
                o_mem.wdata = i_rdata;
                o_mem.raddr = idx_p2[AW-1:0];
                n_idx       = idx_p1[AW-1:0];
                if (last_shift) n_count = cnt_m1;
            end
            spq_pkg::ST_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spq_pkg::ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_idx    <= n_idx;
        r_id     <= n_id;
        r_pri    <= n_pri;
        r_status <= n_status;
        r_rid    <= n_rid;
        r_rpri   <= n_rpri;
    end

    assign o_in_ready   = (r_state == spq_pkg::ST_IDLE);
    assign o_res_valid  = (r_state == spq_pkg::ST_DONE);
    assign o_res.status = r_status;
    assign o_res.rid    = r_rid;
    assign o_res.rpri   = r_rpri;
    assign o_res.count  = spq_pkg::COUNT_OUT_W'(r_count);
    assign o_res.empty  = empty;

endmodule

// ----- rtl/core/spq_out.sv -----
// output register stage of the result stream
module spq_out (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  spq_pkg::t_result i_res,
    output logic             o_valid,
    input  logic             i_ready,
    output spq_pkg::t_result o_res
);

    logic             r_valid;
    spq_pkg::t_result r_res;

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ----- rtl/core/sorted_priority_queue_with_delete.sv -----
// top level of the sorted priority queue with delete by identifier
//
// usage
// - slave stream: one item is one operation; tuser carries the operation
//   (insert, pop tail, delete by identifier), tdata the identifier and the
//   priority. the block takes an item only when it is idle
// - master stream: exactly one result item per operation: status in tuser,
//   popped or deleted entry, new entry count and empty flag in tdata
// - entries sit sorted by ascending priority in one ram with a registered
//   read; the sequencer walks that ram one entry per cycle
// - a pop reads the tail entry; an insert walks from the tail, moving larger
//   entries up one place; a delete searches from the head and then closes
//   the gap; full insert, empty pop or delete and unused kind go straight to the result
// - in the cycle after the result leaves the sequencer the next item can be
//   taken; a new item is not taken while the sequencer still works the last
// - the result goes into an output register; while it waits the block
//   takes and works the next item, and stalls only when a second result
//   is ready and the register is still held by a stalled receiver
// - reset empties the queue at once (count cleared); ram contents are
//   left as they are, since only entries below the count are ever used
module sorted_priority_queue_with_delete (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input operations
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // entry_id[15:0], entry_priority[23:16]
    input  logic [1:0]  s_axis_tuser,  // kind[1:0]
    // results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // result_id[15:0], result_priority[23:16],
                                       // entry_count[28:24], is_empty[29], zero[31:30]
    output logic [1:0]  m_axis_tuser   // status[1:0]
);

    spq_pkg::t_mem_req mem_req;
    spq_pkg::t_entry   mem_rdata;
    spq_pkg::t_result  ctrl_res, out_res;
    logic              ctrl_res_valid, out_ready;

    // entry table
    spq_ram #(
        .WIDTH (spq_pkg::ENTRY_W),
        .DEPTH (spq_pkg::QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wdata),
        .i_raddr (mem_req.raddr),
        .o_rdata (mem_rdata)
    );

    // operation sequencer
    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_kind      (s_axis_tuser),
        .i_id        (s_axis_tdata[15:0]),
        .i_pri       (s_axis_tdata[23:16]),
        .o_mem       (mem_req),
        .i_rdata     (mem_rdata),
        .o_res_valid (ctrl_res_valid),
        .i_res_ready (out_ready),
        .o_res       (ctrl_res)
    );

    // result register toward the receiver
    spq_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (ctrl_res_valid),
        .o_ready (out_ready),
        .i_res   (ctrl_res),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (out_res)
    );

    assign m_axis_tdata = {2'b00, out_res.empty, out_res.count, out_res.rpri, out_res.rid};
    assign m_axis_tuser = out_res.status;

endmodule
